FILE: rtl/core/sspg_pkg.sv
// shared types, constants and the quarter-wave sine function of the setpoint generator
`default_nettype none
package sspg_pkg;

	// number of joints, fixed by the two result fields
	localparam int unsigned CHANNELS = 2;

	// default quarter-wave table resolution
	localparam int unsigned SINE_TABLE_BITS_DEF = 10;

	localparam int unsigned DATA_W = 32;

	// register groups, each holding one register per channel
	localparam int unsigned GRP_PHASE_STEP = 0;
	localparam int unsigned GRP_AMPLITUDE  = 1;
	localparam int unsigned GRP_OFFSET     = 2;
	localparam int unsigned GRP_COUNT      = 3;

	localparam int unsigned REG_COUNT = GRP_COUNT * CHANNELS;
	localparam int unsigned IDX_W     = $clog2(REG_COUNT);

	// count line of transactions in flight: count, phase, table, product, sum
	localparam int unsigned PIPE_DEPTH = 5;

	// pi/2 in unsigned Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
	} cfg_wr_t;

	// sin(pi/2 * k / 2^bits) in Q1.15, taylor series to x^17 in Q30, evaluated at elaboration
	function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned bits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x    = (HALF_PI_Q30 * 64'(k)) >> bits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd272;
		sum  = sum + signed'(term);
		if (sum <= 64'sd0) begin
			return 15'd0;
		end
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32767) begin
			sum = 64'sd32767;
		end
		return sum[14:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sspg_if.sv
// valid/ready channel interfaces for the tick input and the setpoint result
`default_nettype none
interface sspg_tick_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink   (input valid, input advance, output ready);
endinterface

interface sspg_setpoint_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_a;
	logic signed [31:0] position_b;

	modport source (output valid, output position_a, output position_b, input ready);
	modport sink   (input valid, input position_a, input position_b, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sspg_sine_rom.sv
// quarter-wave sine rom with registered read
`default_nettype none
module sspg_sine_rom #(
	parameter int unsigned TABLE_BITS = sspg_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic [TABLE_BITS:0]   addr,
	output logic      [14:0]           data_q
);

	localparam int unsigned DEPTH = (1 << TABLE_BITS) + 1;

	logic [14:0] rom_w [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_entry
		localparam logic [14:0] ENTRY = sspg_pkg::quarter_sine(k, TABLE_BITS);
		assign rom_w[k] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/sspg_lane.sv
// one joint lane: its registers, phase multiply, sine lookup, scaling and saturation
`default_nettype none
module sspg_lane #(
	parameter int unsigned TABLE_BITS = sspg_pkg::SINE_TABLE_BITS_DEF,
	parameter int unsigned LANE       = 0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire sspg_pkg::cfg_wr_t       cfg,
	input  wire logic [31:0]             count,
	output logic signed [31:0]           pos_s4
);

	localparam int unsigned IW = sspg_pkg::IDX_W;
	localparam int unsigned AW = TABLE_BITS + 1;
	localparam logic [IW-1:0] STEP_IDX =
		IW'(sspg_pkg::GRP_PHASE_STEP * sspg_pkg::CHANNELS + LANE);
	localparam logic [IW-1:0] AMP_IDX =
		IW'(sspg_pkg::GRP_AMPLITUDE * sspg_pkg::CHANNELS + LANE);
	localparam logic [IW-1:0] OFS_IDX =
		IW'(sspg_pkg::GRP_OFFSET * sspg_pkg::CHANNELS + LANE);
	localparam logic [AW-1:0] QUARTER = AW'(1 << TABLE_BITS);

	logic        [31:0] step_q;
	logic signed [31:0] amp_q;
	logic signed [31:0] ofs_q;

	logic        [31:0] phase_s1;
	logic        [14:0] mag_s2;
	logic               neg_s2;
	logic signed [48:0] prod_s3;

	logic [TABLE_BITS-1:0] idx;
	logic [AW-1:0]         addr;
	logic signed [16:0]    sine;
	logic signed [48:0]    rnd;
	logic signed [33:0]    quo;
	logic signed [34:0]    sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			amp_q  <= '0;
			ofs_q  <= '0;
		end else if (cfg.en) begin
			if (cfg.index == STEP_IDX) begin
				step_q <= cfg.data;
			end
			if (cfg.index == AMP_IDX) begin
				amp_q <= signed'(cfg.data);
			end
			if (cfg.index == OFS_IDX) begin
				ofs_q <= signed'(cfg.data);
			end
		end
	end

	// odd quadrants read the table mirrored
	always_comb begin
		idx  = phase_s1[29 -: TABLE_BITS];
		addr = phase_s1[30] ? (QUARTER - {1'b0, idx}) : {1'b0, idx};
	end

	sspg_sine_rom #(
		.TABLE_BITS (TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.addr   (addr),
		.data_q (mag_s2)
	);

	always_comb begin
		sine = neg_s2 ? -signed'({2'b00, mag_s2}) : signed'({2'b00, mag_s2});
		rnd  = prod_s3 + 49'sd16384;
		quo  = rnd[48:15];
		sum  = 35'(ofs_q) + 35'(quo);
	end

	always_ff @(posedge clk) begin
		phase_s1 <= 32'(step_q * count);
		neg_s2   <= phase_s1[31];
		prod_s3  <= 49'(amp_q) * 49'(sine);
		if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
			pos_s4 <= sum[31:0];
		end else if (sum[34]) begin
			pos_s4 <= 32'sh8000_0000;
		end else begin
			pos_s4 <= 32'sh7fff_ffff;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sspg_merge.sv
// merges the lane results into the held setpoint transaction
`default_nettype none
module sspg_merge (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               capture,
	input  wire logic signed [31:0] pos [sspg_pkg::CHANNELS],
	sspg_setpoint_if.source         setpoint
);

	logic               valid_q;
	logic signed [31:0] pos_a_q;
	logic signed [31:0] pos_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (capture) begin
			valid_q <= 1'b1;
		end else if (setpoint.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			pos_a_q <= pos[0];
			pos_b_q <= pos[1];
		end
	end

	assign setpoint.valid      = valid_q;
	assign setpoint.position_a = pos_a_q;
	assign setpoint.position_b = pos_b_q;

endmodule
`default_nettype wire

FILE: rtl/core/two_channel_sine_setpoint_generator_core.sv
// top level of the two-joint sine setpoint generator
`default_nettype none
// each tick transaction either advances the shared 32-bit tick count by one (advance = 1) or
// restarts it at zero (advance = 0), and then yields one setpoint transaction with a position
// for each joint: offset + amplitude * sin(2*pi * phase_step * count / 2^32), amplitude and
// offset in signed Q16.16, sine from a quarter-wave Q1.15 table of 2^SINE_TABLE_BITS + 1
// entries addressed by the top phase bits without interpolation, product rounded half up and
// the sum saturated to 32 bits. the joints run in identical lanes side by side. the count
// register loads on the edge that takes a tick; its setpoint then goes through the phase
// multiply, table read, amplitude multiply, round and saturate and output registers in turn
// before it is valid. the next tick can be taken the cycle after the setpoint is taken,
// so the four-stage lane pipeline plus the output register hold one transaction at a time.
// registers are to be written through the plain write port only while no transaction is in
// flight, which the block does not enforce; indexes 0..5 are phase_step_a/b, amplitude_a/b,
// offset_a/b and other indexes are ignored
module two_channel_sine_setpoint_generator_core #(
	parameter int unsigned SINE_TABLE_BITS = sspg_pkg::SINE_TABLE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [sspg_pkg::IDX_W-1:0]  wr_index,
	input  wire logic [sspg_pkg::DATA_W-1:0] wr_data,
	sspg_tick_if.sink                        tick,
	sspg_setpoint_if.source                  setpoint
);

	// shared tick count
	logic [31:0] count_q;
	// one transaction at a time, from tick taken until setpoint taken
	logic        busy_q;
	// marks the stage holding the transaction in flight
	logic [sspg_pkg::PIPE_DEPTH-1:0] vld_q;

	logic              tick_acc;
	logic              set_acc;
	sspg_pkg::cfg_wr_t cfg_wr;

	logic signed [31:0] lane_pos [sspg_pkg::CHANNELS];

	assign tick_acc   = tick.valid && tick.ready;
	assign set_acc    = setpoint.valid && setpoint.ready;
	assign tick.ready = !busy_q;

	assign cfg_wr = '{en: wr_en, index: wr_index, data: wr_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			vld_q   <= '0;
		end else begin
			// restart puts the count at zero so the restart tick yields just the offsets
			if (tick_acc) begin
				count_q <= tick.advance ? count_q + 32'd1 : 32'd0;
			end
			if (tick_acc) begin
				busy_q <= 1'b1;
			end else if (set_acc) begin
				busy_q <= 1'b0;
			end
			vld_q <= {vld_q[sspg_pkg::PIPE_DEPTH-2:0], tick_acc};
		end
	end

	// one lane per joint
	for (genvar c = 0; c < sspg_pkg::CHANNELS; c++) begin : g_lane
		sspg_lane #(
			.TABLE_BITS (SINE_TABLE_BITS),
			.LANE       (c)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_wr),
			.count  (count_q),
			.pos_s4 (lane_pos[c])
		);
	end

	// lane results land in the output register once the last stage holds them
	sspg_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.capture  (vld_q[sspg_pkg::PIPE_DEPTH-1]),
		.pos      (lane_pos),
		.setpoint (setpoint)
	);

endmodule
`default_nettype wire

FILE: tb/sv/sspg_setpoint_checker.sv
// checker that predicts each setpoint transaction of the sine setpoint generator and compares it
`timescale 1ns / 1ps
module sspg_setpoint_checker
	import sspg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_index,
	input  wire logic [DATA_W-1:0]  wr_data,
	input  wire logic               tick_valid,
	input  wire logic               tick_ready,
	input  wire logic               tick_advance,
	input  wire logic               setpoint_valid,
	input  wire logic               setpoint_ready,
	input  wire logic signed [31:0] position_a,
	input  wire logic signed [31:0] position_b,
	output int                      fail_count,
	output int                      pending
);

	localparam int unsigned TBL_BITS = SINE_TABLE_BITS_DEF;
	localparam int unsigned TBL_N    = 1 << TBL_BITS;
	localparam longint      POS_LIMIT = 64'sd2147483647;
	localparam longint      NEG_LIMIT = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] position_a;
		logic signed [31:0] position_b;
	} setpoint_t;

	int                 sine_q15 [0:TBL_N];
	logic        [31:0] step_word [CHANNELS];
	logic signed [31:0] amp_word  [CHANNELS];
	logic signed [31:0] ofs_word  [CHANNELS];
	logic        [31:0] tick_count;
	setpoint_t          expected_setpoints [$];
	int                 results_seen;

	// sin(pi/2 * k/N) in Q1.15 from a Taylor series in unsigned Q30
	function automatic int quarter_wave_q15(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		x    = (HALF_PI_Q30 * 64'(k)) >> TBL_BITS;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int unsigned n = 1; n <= 8; n++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc <= 0) begin
			return 0;
		end
		acc = (acc + 16384) / 32768;
		if (acc > 32767) begin
			acc = 32767;
		end
		return int'(acc);
	endfunction

	function automatic logic signed [31:0] joint_position(input int ch);
		logic [31:0] phase;
		logic [1:0]  quad;
		int unsigned idx;
		int          sn;
		longint      q;
		longint      s;
		phase = step_word[ch] * tick_count;
		quad  = phase[31:30];
		idx   = int'(phase >> (30 - TBL_BITS)) & (TBL_N - 1);
		sn    = quad[0] ? sine_q15[TBL_N - idx] : sine_q15[idx];
		if (quad[1]) begin
			sn = -sn;
		end
		// round half up out of Q.31, floor by arithmetic shift
		q = (longint'(amp_word[ch]) * longint'(sn) + 64'sd16384) >>> 15;
		s = longint'(ofs_word[ch]) + q;
		if (s > POS_LIMIT) begin
			s = POS_LIMIT;
		end
		if (s < NEG_LIMIT) begin
			s = NEG_LIMIT;
		end
		return s[31:0];
	endfunction

	task automatic report_fault(input string msg);
		$display("%0t ERROR: %s", $time, msg);
		fail_count++;
	endtask

	initial begin
		fail_count   = 0;
		pending      = 0;
		results_seen = 0;
		for (int unsigned k = 0; k <= TBL_N; k++) begin
			sine_q15[k] = quarter_wave_q15(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		setpoint_t want;
		setpoint_t next_sp;
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				step_word[c] = '0;
				amp_word[c]  = '0;
				ofs_word[c]  = '0;
			end
			tick_count = '0;
			expected_setpoints.delete();
			pending = 0;
		end else begin
			if (setpoint_valid && setpoint_ready) begin
				if (expected_setpoints.size() == 0) begin
					report_fault($sformatf("setpoint %0d with nothing outstanding: a=%h b=%h",
						results_seen, position_a, position_b));
				end else begin
					want = expected_setpoints.pop_front();
					if (position_a !== want.position_a) begin
						report_fault($sformatf("setpoint %0d position_a: expected %h, got %h",
							results_seen, want.position_a, position_a));
					end
					if (position_b !== want.position_b) begin
						report_fault($sformatf("setpoint %0d position_b: expected %h, got %h",
							results_seen, want.position_b, position_b));
					end
				end
				results_seen++;
			end
			if (wr_en && wr_index < REG_COUNT) begin
				case (wr_index / CHANNELS)
					GRP_PHASE_STEP: step_word[wr_index % CHANNELS] = wr_data;
					GRP_AMPLITUDE:  amp_word[wr_index % CHANNELS]  = wr_data;
					GRP_OFFSET:     ofs_word[wr_index % CHANNELS]  = wr_data;
					default: ;
				endcase
			end
			if (tick_valid && tick_ready) begin
				tick_count = tick_advance ? tick_count + 32'd1 : 32'd0;
				next_sp.position_a = joint_position(0);
				next_sp.position_b = joint_position(1);
				expected_setpoints.push_back(next_sp);
			end
			pending = expected_setpoints.size();
		end
	end

endmodule

FILE: tb/sv/tb_two_channel_sine_setpoint_generator_core.sv
// testbench top of the two-channel sine setpoint generator: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_two_channel_sine_setpoint_generator_core;
	import sspg_pkg::*;

	// register indexes, group major, joint A first
	localparam logic [IDX_W-1:0] IDX_STEP_A   = IDX_W'(GRP_PHASE_STEP * CHANNELS + 0);
	localparam logic [IDX_W-1:0] IDX_STEP_B   = IDX_W'(GRP_PHASE_STEP * CHANNELS + 1);
	localparam logic [IDX_W-1:0] IDX_AMP_A    = IDX_W'(GRP_AMPLITUDE * CHANNELS + 0);
	localparam logic [IDX_W-1:0] IDX_AMP_B    = IDX_W'(GRP_AMPLITUDE * CHANNELS + 1);
	localparam logic [IDX_W-1:0] IDX_OFS_A    = IDX_W'(GRP_OFFSET * CHANNELS + 0);
	localparam logic [IDX_W-1:0] IDX_OFS_B    = IDX_W'(GRP_OFFSET * CHANNELS + 1);
	// indexes past the register list, which the block must ignore
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = IDX_W'(REG_COUNT);
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = '1;

	localparam int RANDOM_ITEMS   = 1430;
	// cycles without any accepted transaction before the run is called hung;
	// well above the long result hold-off plus a register load and a sender gap
	localparam int WATCHDOG_LIMIT = 2000;
	// quiet time after the last group, longer than the path from a tick to its setpoint
	localparam int DRAIN_CYCLES   = 12;
	localparam int LONG_HOLD      = 250;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [DATA_W-1:0] wr_data;
	int                fail_count;
	int                pending;
	int                burst_left;

	sspg_tick_if     tick_ch ();
	sspg_setpoint_if setpoint_ch ();

	two_channel_sine_setpoint_generator_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.tick     (tick_ch),
		.setpoint (setpoint_ch)
	);

	// the checker sees every handshake and register write and keeps the expected setpoints
	sspg_setpoint_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.tick_valid     (tick_ch.valid),
		.tick_ready     (tick_ch.ready),
		.tick_advance   (tick_ch.advance),
		.setpoint_valid (setpoint_ch.valid),
		.setpoint_ready (setpoint_ch.ready),
		.position_a     (setpoint_ch.position_a),
		.position_b     (setpoint_ch.position_b),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// register values: mostly the corners of the 32-bit range, single bits, or anything
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	// load all six registers back to back, optionally followed by writes past the list;
	// only called with nothing in flight
	task automatic load_setting(input logic [31:0] step_a, input logic [31:0] step_b,
		input logic [31:0] amp_a, input logic [31:0] amp_b,
		input logic [31:0] ofs_a, input logic [31:0] ofs_b, input bit with_spare);
		logic [31:0] vals [REG_COUNT];
		vals[IDX_STEP_A] = step_a;
		vals[IDX_STEP_B] = step_b;
		vals[IDX_AMP_A]  = amp_a;
		vals[IDX_AMP_B]  = amp_b;
		vals[IDX_OFS_A]  = ofs_a;
		vals[IDX_OFS_B]  = ofs_b;
		for (int r = 0; r < REG_COUNT; r++) begin
			wr_en    <= 1'b1;
			wr_index <= IDX_W'(r);
			wr_data  <= vals[r];
			@(posedge clk);
		end
		// spare writes come last so an aliasing decoder would clobber a live register
		if (with_spare) begin
			wr_index <= IDX_SPARE_LO;
			wr_data  <= $urandom();
			@(posedge clk);
			wr_index <= IDX_SPARE_HI;
			wr_data  <= $urandom();
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// offer one tick transaction per entry, in bursts with random gaps, then wait until
	// every setpoint of the group has been taken
	task automatic play_ticks(input bit advs[$]);
		int gap;
		foreach (advs[k]) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(0, 12);
				burst_left = $urandom_range(1, 30);
				if (gap > 0) begin
					// payload wiggles while valid is low
					tick_ch.valid   <= 1'b0;
					tick_ch.advance <= 1'($urandom());
					repeat (gap) @(posedge clk);
				end
			end
			// valid stays high across back-to-back transactions
			tick_ch.valid   <= 1'b1;
			tick_ch.advance <= advs[k];
			@(posedge clk);
			while (!tick_ch.ready) @(posedge clk);
			burst_left--;
		end
		tick_ch.valid <= 1'b0;
		// wait for the next edge, so the checker has counted the last tick
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// result side: a rotating stall pattern reloaded now and then, all-ones some of the
	// time, plus two long hold-offs so the block backs up into the tick channel
	initial begin
		int          hold;
		int          rx_seen;
		int          reload;
		logic [15:0] pattern;
		hold    = 0;
		rx_seen = 0;
		reload  = 0;
		pattern = '1;
		setpoint_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (setpoint_ch.valid && setpoint_ch.ready) begin
				rx_seen++;
				if (rx_seen == 150 || rx_seen == 900) begin
					hold = LONG_HOLD;
				end
			end
			if (reload == 0) begin
				reload = $urandom_range(32, 160);
				case ($urandom_range(0, 3))
					0:       pattern = '1;
					1:       pattern = 16'($urandom());
					2:       pattern = 16'($urandom() | $urandom());
					default: pattern = 16'($urandom() & $urandom());
				endcase
				// never a pattern that stalls forever
				pattern[0] = 1'b1;
			end
			reload--;
			if (hold > 0) begin
				hold--;
				setpoint_ch.ready <= 1'b0;
			end else begin
				setpoint_ch.ready <= pattern[0];
				pattern = {pattern[0], pattern[15:1]};
			end
		end
	end

	// watchdog: any stretch without an accepted transaction beyond the limit is a hang
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (tick_ch.valid && tick_ch.ready)
				|| (setpoint_ch.valid && setpoint_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		bit advs[$];
		int sent;
		int n;
		bit noisy;
		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= '0;
		wr_data         <= '0;
		tick_ch.valid   <= 1'b0;
		tick_ch.advance <= 1'b0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: every register zero, so both positions stay at zero
		advs = {1'b1, 1'b0};
		play_ticks(advs);

		// quarter-turn step walks joint A through all four quadrants and wraps the phase;
		// the all-ones step puts joint B just below a full turn, read next to the zero table entry;
		// amplitude extremes of both signs, and writes past the register list
		load_setting(32'h4000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0000, 32'h0000_0000, 1'b1);
		advs = {1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
		play_ticks(advs);

		// saturation at both limits; restart gives the bare offset, the tick after it count 1
		load_setting(32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		advs = {1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		play_ticks(advs);

		// one table entry per tick on A with unit amplitude; smallest negative amplitude on B
		load_setting(32'h0010_0000, 32'hC00F_FFFF, 32'h0001_0000, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		advs = {1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
		play_ticks(advs);

		// random settings, each followed by a run of ticks, now and then a long one; mostly advancing
		// ticks with a rare restart, and now and then a noisy group with restarts half of the time
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			load_setting(pick_word(), pick_word(), pick_word(), pick_word(),
				pick_word(), pick_word(), $urandom_range(0, 3) == 0);
			n     = ($urandom_range(0, 5) == 0) ? $urandom_range(120, 220)
				: $urandom_range(10, 90);
			noisy = $urandom_range(0, 7) == 0;
			advs.delete();
			for (int k = 0; k < n; k++) begin
				advs.push_back(noisy ? 1'($urandom()) : ($urandom_range(0, 15) != 0));
			end
			play_ticks(advs);
			sent += n;
		end

		// anything that shows up now has no transaction behind it
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/sspg_pkg.sv
rtl/core/sspg_if.sv
rtl/core/sspg_sine_rom.sv
rtl/core/sspg_lane.sv
rtl/core/sspg_merge.sv
rtl/core/two_channel_sine_setpoint_generator_core.sv
tb/sv/sspg_setpoint_checker.sv
tb/sv/tb_two_channel_sine_setpoint_generator_core.sv
